### src/trp_pkg.sv
// ----------------------------------------------------------------------------
// Timestamped record parser package
// Shared character codes, error positions, register indexes and line state.
// ----------------------------------------------------------------------------
package trp_pkg;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Error position codes.
    localparam logic [2:0] POS_YEAR   = 3'd0;
    localparam logic [2:0] POS_MONTH  = 3'd1;
    localparam logic [2:0] POS_DAY    = 3'd2;
    localparam logic [2:0] POS_HOUR   = 3'd3;
    localparam logic [2:0] POS_MINUTE = 3'd4;
    localparam logic [2:0] POS_TEMP   = 3'd5;
    localparam logic [2:0] POS_EXTRA  = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAX_DAY    = 2'd0;
    localparam logic [1:0] REG_MAX_HOUR   = 2'd1;
    localparam logic [1:0] REG_MAX_MINUTE = 2'd2;
    localparam logic [1:0] REG_TEMP_LIMIT = 2'd3;

    localparam logic [2:0] CNT_MAX = 3'd7;
    localparam logic [7:0] MONTH_MAX = 8'd12;

    typedef struct packed {
        logic [13:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [15:0] temp;
        logic [2:0]  field_index;
        logic        err_seen;
        logic [2:0]  err_field;
    } t_line_state;

    typedef struct packed {
        logic [7:0]  max_day;
        logic [7:0]  max_hour;
        logic [7:0]  max_minute;
        logic [14:0] temp_limit;
    } t_cfg;

    typedef struct packed {
        logic       err_flag;
        logic [2:0] err_pos;
    } t_verdict;

    // Positional year weight applied to one digit.
    function automatic logic [13:0] year_term(input logic [3:0] d, input logic [1:0] pos);
        logic [13:0] w;
        begin
            case (pos)
                2'd0:    w = 14'(d) * 14'd1000;
                2'd1:    w = 14'(d) * 14'd100;
                2'd2:    w = 14'(d) * 14'd10;
                default: w = 14'(d);
            endcase
            return w;
        end
    endfunction

endpackage

### src/trp_accum.sv
// ----------------------------------------------------------------------------
// Record field accumulator
// Holds the per-line state and folds one byte into it per advance.
// ----------------------------------------------------------------------------
module trp_accum (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [7:0]            i_byte,
    output trp_pkg::t_line_state  o_state,
    output logic [31:0]           o_line_counter
);

    trp_pkg::t_line_state r_st, n_st;
    logic [2:0]  r_digit_count, n_digit_count;
    logic        r_neg, n_neg;
    logic [31:0] r_line_counter, n_line_counter;

    logic        w_is_digit;
    logic [7:0]  w_d8;
    logic [15:0] w_d16;
    logic [15:0] w_term;
    logic [7:0]  w_acc_old;
    logic [7:0]  w_acc_new;

    assign w_is_digit = (i_byte >= trp_pkg::CHAR_ZERO) && (i_byte <= trp_pkg::CHAR_NINE);
    assign w_d8       = i_byte - trp_pkg::CHAR_ZERO;
    assign w_d16      = {8'h00, i_byte} - {8'h00, trp_pkg::CHAR_ZERO};
    assign w_term     = r_neg ? (16'h0000 - w_d16) : w_d16;

    always_comb begin
        case (r_st.field_index)
            trp_pkg::POS_MONTH: w_acc_old = r_st.month;
            trp_pkg::POS_DAY:   w_acc_old = r_st.day;
            trp_pkg::POS_HOUR:  w_acc_old = r_st.hour;
            default:            w_acc_old = r_st.minute;
        endcase
        if (r_digit_count == 3'd0) begin
            w_acc_new = w_d8;
        end else begin
            w_acc_new = {w_acc_old[4:0], 3'b000} + {w_acc_old[6:0], 1'b0} + w_d8;
        end
    end

    always_comb begin
        n_st           = r_st;
        n_digit_count  = r_digit_count;
        n_neg          = r_neg;
        n_line_counter = r_line_counter;
        if (i_en) begin
            if (i_byte == trp_pkg::CHAR_NL) begin
                n_st           = '0;
                n_digit_count  = 3'd0;
                n_neg          = 1'b0;
                n_line_counter = r_line_counter + 32'd1;
            end else if (i_byte == trp_pkg::CHAR_SEMI) begin
                n_digit_count = 3'd0;
                if (r_st.field_index != trp_pkg::CNT_MAX) begin
                    n_st.field_index = r_st.field_index + 3'd1;
                end
            end else begin
                if (r_st.field_index < trp_pkg::POS_TEMP) begin
                    if (!w_is_digit) begin
                        n_st.err_seen  = 1'b1;
                        n_st.err_field = r_st.field_index;
                    end else if (r_st.field_index == trp_pkg::POS_YEAR) begin
                        if (r_digit_count > 3'd3) begin
                            n_st.err_seen  = 1'b1;
                            n_st.err_field = trp_pkg::POS_YEAR;
                        end else begin
                            n_st.year = r_st.year
                                + trp_pkg::year_term(i_byte[3:0], r_digit_count[1:0]);
                        end
                    end else begin
                        if (r_digit_count > 3'd1) begin
                            n_st.err_seen  = 1'b1;
                            n_st.err_field = r_st.field_index;
                        end
                        case (r_st.field_index)
                            trp_pkg::POS_MONTH: n_st.month  = w_acc_new;
                            trp_pkg::POS_DAY:   n_st.day    = w_acc_new;
                            trp_pkg::POS_HOUR:  n_st.hour   = w_acc_new;
                            default:            n_st.minute = w_acc_new;
                        endcase
                    end
                end else if (r_st.field_index == trp_pkg::POS_TEMP) begin
                    if (i_byte == trp_pkg::CHAR_MINUS) begin
                        n_neg = 1'b1;
                    end else if (r_digit_count == 3'd0) begin
                        n_st.temp = w_term;
                    end else begin
                        n_st.temp = {r_st.temp[12:0], 3'b000} + {r_st.temp[14:0], 1'b0}
                                  + w_term;
                    end
                end
                if (r_digit_count != trp_pkg::CNT_MAX) begin
                    n_digit_count = r_digit_count + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st           <= '0;
            r_digit_count  <= 3'd0;
            r_neg          <= 1'b0;
            r_line_counter <= 32'd0;
        end else begin
            r_st           <= n_st;
            r_digit_count  <= n_digit_count;
            r_neg          <= n_neg;
            r_line_counter <= n_line_counter;
        end
    end

    assign o_state        = r_st;
    assign o_line_counter = r_line_counter;

endmodule

### src/trp_check.sv
// ----------------------------------------------------------------------------
// Record limit checker
// Applies the end-of-line limit checks; the last failing check wins.
// ----------------------------------------------------------------------------
module trp_check (
    input  trp_pkg::t_line_state i_state,
    input  trp_pkg::t_cfg        i_cfg,
    output trp_pkg::t_verdict    o_verdict
);

    logic signed [16:0] w_temp;
    logic signed [16:0] w_lim;
    logic               w_bad_month, w_bad_day, w_bad_hour, w_bad_minute;
    logic               w_bad_temp, w_bad_extra;

    assign w_temp = 17'($signed(i_state.temp));
    assign w_lim  = $signed({2'b00, i_cfg.temp_limit});

    assign w_bad_month  = (i_state.month == 8'd0) || (i_state.month > trp_pkg::MONTH_MAX);
    assign w_bad_day    = (i_state.day == 8'd0) || (i_state.day > i_cfg.max_day);
    assign w_bad_hour   = i_state.hour > i_cfg.max_hour;
    assign w_bad_minute = i_state.minute > i_cfg.max_minute;
    assign w_bad_temp   = (w_temp > w_lim) || (w_temp < -w_lim);
    assign w_bad_extra  = i_state.field_index > trp_pkg::POS_TEMP;

    always_comb begin
        o_verdict.err_flag = 1'b1;
        if (w_bad_extra) begin
            o_verdict.err_pos = trp_pkg::POS_EXTRA;
        end else if (w_bad_temp) begin
            o_verdict.err_pos = trp_pkg::POS_TEMP;
        end else if (w_bad_minute) begin
            o_verdict.err_pos = trp_pkg::POS_MINUTE;
        end else if (w_bad_hour) begin
            o_verdict.err_pos = trp_pkg::POS_HOUR;
        end else if (w_bad_day) begin
            o_verdict.err_pos = trp_pkg::POS_DAY;
        end else if (w_bad_month) begin
            o_verdict.err_pos = trp_pkg::POS_MONTH;
        end else if (i_state.err_seen) begin
            o_verdict.err_pos = i_state.err_field;
        end else begin
            o_verdict.err_flag = 1'b0;
            o_verdict.err_pos  = trp_pkg::POS_YEAR;
        end
    end

endmodule

### src/timestamped_record_parser.sv
// ----------------------------------------------------------------------------
// Timestamped record parser
// Parses "year;month;day;hour;minute;temperature" text lines byte by byte.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one ASCII byte per beat (i_valid/o_stall).
// A byte is taken whenever i_valid is high and o_stall is low, and the block
// can take one byte in every cycle. Each byte lands in an input register and
// is folded into the line state from there.
// A newline byte produces exactly one record beat on the output channel
// (o_valid/i_stall) through the output register; other bytes produce none.
// The record carries the decoded fields, a 0-based line number and an error
// flag with the position of the last error found in that line.
// When the receiver stalls, the pending record holds in the output register.
// Bytes that are not newlines keep flowing past it; a newline waits in the
// input register, and o_stall goes high, until the output register empties.
// With o_stall low, one byte per cycle goes through the single accumulate step.
// A synchronous active-low reset clears the line state, the line counter and
// both valid flags, and loads the limit registers with their defaults.
// The limit registers are written through i_cfg_we/i_cfg_index/i_cfg_data
// by the user only while no line is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module timestamped_record_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_byte,
    // record output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [13:0]        o_year_value,
    output logic [7:0]         o_month_value,
    output logic [7:0]         o_day_value,
    output logic [7:0]         o_hour_value,
    output logic [7:0]         o_minute_value,
    output logic signed [15:0] o_temperature,
    output logic [31:0]        o_line_index,
    output logic               o_error_flag,
    output logic [2:0]         o_error_position,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data
);

    // Input register: one byte waiting to be folded into the line state.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Output register holding the finished record.
    logic        r_out_valid;
    logic [13:0] r_year;
    logic [7:0]  r_month, r_day, r_hour, r_minute;
    logic [15:0] r_temp;
    logic [31:0] r_line;
    logic        r_err_flag;
    logic [2:0]  r_err_pos;

    trp_pkg::t_cfg        r_cfg;
    trp_pkg::t_line_state w_state;
    trp_pkg::t_verdict    w_verdict;
    logic [31:0]          w_line_counter;

    logic w_nl;
    logic w_adv;
    logic w_in_take;
    logic w_out_take;

    // A newline can only move on when the output register is free or being
    // emptied this cycle; every other byte moves on unconditionally.
    assign w_nl       = (r_in_byte == trp_pkg::CHAR_NL);
    assign w_out_take = r_out_valid && !i_stall;
    assign w_adv      = r_in_valid && (!w_nl || !r_out_valid || !i_stall);
    assign o_stall    = r_in_valid && !w_adv;
    assign w_in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_char_byte;
        end
    end

    // Limit registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_day    <= 8'd31;
            r_cfg.max_hour   <= 8'd24;
            r_cfg.max_minute <= 8'd60;
            r_cfg.temp_limit <= 15'd99;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                trp_pkg::REG_MAX_DAY:    r_cfg.max_day    <= i_cfg_data[7:0];
                trp_pkg::REG_MAX_HOUR:   r_cfg.max_hour   <= i_cfg_data[7:0];
                trp_pkg::REG_MAX_MINUTE: r_cfg.max_minute <= i_cfg_data[7:0];
                trp_pkg::REG_TEMP_LIMIT: r_cfg.temp_limit <= i_cfg_data;
                default:                 r_cfg.temp_limit <= r_cfg.temp_limit;
            endcase
        end
    end

    trp_accum u_accum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_adv),
        .i_byte         (r_in_byte),
        .o_state        (w_state),
        .o_line_counter (w_line_counter)
    );

    trp_check u_check (
        .i_state   (w_state),
        .i_cfg     (r_cfg),
        .o_verdict (w_verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_nl) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // The record is captured from the line state before the newline clears it.
    always_ff @(posedge i_clk) begin
        if (w_adv && w_nl) begin
            r_year     <= w_state.year;
            r_month    <= w_state.month;
            r_day      <= w_state.day;
            r_hour     <= w_state.hour;
            r_minute   <= w_state.minute;
            r_temp     <= w_state.temp;
            r_line     <= w_line_counter;
            r_err_flag <= w_verdict.err_flag;
            r_err_pos  <= w_verdict.err_pos;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_year_value     = r_year;
    assign o_month_value    = r_month;
    assign o_day_value      = r_day;
    assign o_hour_value     = r_hour;
    assign o_minute_value   = r_minute;
    assign o_temperature    = $signed(r_temp);
    assign o_line_index     = r_line;
    assign o_error_flag     = r_err_flag;
    assign o_error_position = r_err_pos;

`ifndef SYNTHESIS
    a_nl_makes_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_nl) |=> r_out_valid)
        else $error("newline advanced without producing a record");

    a_stall_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && w_nl && r_out_valid))
        else $error("input stalled without a blocked newline");

    a_clean_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_err_flag) |-> (r_err_pos == trp_pkg::POS_YEAR))
        else $error("error position set on a clean record");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !(w_adv && w_nl))
        else $error("pending record overwritten while stalled");
`endif

endmodule

### tb/sv/timestamped_record_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamped record parser testbench
// Streams text lines into the parser one byte per beat under random source
// gaps and sink stalls, predicts every record, and checks it field by field.
// ----------------------------------------------------------------------------
module timestamped_record_parser_test;

    // No beat on either channel for this many cycles means the block is hung.
    localparam int unsigned QUIET_LIMIT = 2000;
    // Rough number of random bytes sent under each limit setting.
    localparam int unsigned PHASE_BYTES = 250;
    localparam int unsigned PHASES      = 6;

    // One record as the block should emit it.
    typedef struct packed {
        logic [13:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [15:0] temp;
        logic [31:0] line;
        logic        err;
        logic [2:0]  pos;
    } t_record;

    // One byte waiting to go out. When hold is set, the source waits for
    // every outstanding record to come back before it presents this byte.
    typedef struct packed {
        logic [7:0] ch;
        logic       hold;
    } t_char_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_char_byte = 8'h00;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [13:0]        o_year_value;
    logic [7:0]         o_month_value;
    logic [7:0]         o_day_value;
    logic [7:0]         o_hour_value;
    logic [7:0]         o_minute_value;
    logic signed [15:0] o_temperature;
    logic [31:0]        o_line_index;
    logic               o_error_flag;
    logic [2:0]         o_error_position;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = 2'd0;
    logic [14:0]        i_cfg_data = 15'd0;

    timestamped_record_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_char_byte      (i_char_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_year_value     (o_year_value),
        .o_month_value    (o_month_value),
        .o_day_value      (o_day_value),
        .o_hour_value     (o_hour_value),
        .o_minute_value   (o_minute_value),
        .o_temperature    (o_temperature),
        .o_line_index     (o_line_index),
        .o_error_flag     (o_error_flag),
        .o_error_position (o_error_position),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predicted state of the line being parsed. Everything starts at zero,
    // which is also what reset leaves in the block.
    // ------------------------------------------------------------------------
    logic [2:0]  ln_field   = 3'd0;
    logic [2:0]  ln_digits  = 3'd0;
    logic [13:0] ln_year    = 14'd0;
    logic [7:0]  ln_tm [1:4] = '{default: 8'd0};   // month, day, hour, minute
    logic [15:0] ln_temp    = 16'd0;
    logic        ln_neg     = 1'b0;
    logic        ln_err     = 1'b0;
    logic [2:0]  ln_err_pos = 3'd0;
    logic [31:0] line_count = 32'd0;

    // Our copy of the limit registers, starting from their reset values.
    logic [7:0]  lim_day    = 8'd31;
    logic [7:0]  lim_hour   = 8'd24;
    logic [7:0]  lim_minute = 8'd60;
    logic [14:0] lim_temp   = 15'd99;

    t_char_beat  chars_to_send[$];
    t_record     records_due[$];
    logic [7:0]  line_bytes[$];

    int unsigned chars_queued = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned failures     = 0;
    bit          src_idle     = 1'b1;
    bit          snk_idle     = 1'b1;

    function automatic int unsigned pick_gap(input int unsigned longest);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(6, longest);
    endfunction

    task automatic mark_error(input logic [2:0] pos);
        ln_err     = 1'b1;
        ln_err_pos = pos;
    endtask

    // Folds one accepted byte into the predicted line state. A newline runs
    // the limit checks in the block's order (month, day, hour, minute,
    // temperature, extra fields), so the last failing check sets the
    // position, and files the finished record.
    task automatic parse_char(input logic [7:0] c);
        logic [7:0]  d8;
        logic [15:0] d16;
        logic [15:0] term;
        int          weight;
        int          t;
        int          lim;
        t_record     rec;
        if (c == trp_pkg::CHAR_NL) begin
            t   = int'($signed(ln_temp));
            lim = int'(lim_temp);
            if (ln_tm[trp_pkg::POS_MONTH] < 8'd1 ||
                ln_tm[trp_pkg::POS_MONTH] > trp_pkg::MONTH_MAX)
                mark_error(trp_pkg::POS_MONTH);
            if (ln_tm[trp_pkg::POS_DAY] < 8'd1 || ln_tm[trp_pkg::POS_DAY] > lim_day)
                mark_error(trp_pkg::POS_DAY);
            if (ln_tm[trp_pkg::POS_HOUR] > lim_hour)
                mark_error(trp_pkg::POS_HOUR);
            if (ln_tm[trp_pkg::POS_MINUTE] > lim_minute)
                mark_error(trp_pkg::POS_MINUTE);
            if (t > lim || t < -lim)
                mark_error(trp_pkg::POS_TEMP);
            if (ln_field > trp_pkg::POS_TEMP)
                mark_error(trp_pkg::POS_EXTRA);
            rec.year   = ln_year;
            rec.month  = ln_tm[trp_pkg::POS_MONTH];
            rec.day    = ln_tm[trp_pkg::POS_DAY];
            rec.hour   = ln_tm[trp_pkg::POS_HOUR];
            rec.minute = ln_tm[trp_pkg::POS_MINUTE];
            rec.temp   = ln_temp;
            rec.line   = line_count;
            rec.err    = ln_err;
            rec.pos    = ln_err ? ln_err_pos : trp_pkg::POS_YEAR;
            records_due.push_back(rec);
            line_count = line_count + 32'd1;
            ln_field   = 3'd0;
            ln_digits  = 3'd0;
            ln_year    = 14'd0;
            for (int k = 1; k <= 4; k++) ln_tm[k] = 8'd0;
            ln_temp    = 16'd0;
            ln_neg     = 1'b0;
            ln_err     = 1'b0;
            ln_err_pos = 3'd0;
        end else if (c == trp_pkg::CHAR_SEMI) begin
            ln_digits = 3'd0;
            if (ln_field != trp_pkg::CNT_MAX) ln_field = ln_field + 3'd1;
        end else begin
            // The digit value wraps for non-digits; the temperature field
            // uses it that way on purpose.
            d16 = {8'h00, c} - {8'h00, trp_pkg::CHAR_ZERO};
            d8  = d16[7:0];
            if (ln_field < trp_pkg::POS_TEMP) begin
                if (c < trp_pkg::CHAR_ZERO || c > trp_pkg::CHAR_NINE) begin
                    mark_error(ln_field);
                end else if (ln_field == trp_pkg::POS_YEAR) begin
                    // Year digits past the fourth are flagged and dropped.
                    if (ln_digits > 3'd3) begin
                        mark_error(trp_pkg::POS_YEAR);
                    end else begin
                        case (ln_digits)
                            3'd0:    weight = 1000;
                            3'd1:    weight = 100;
                            3'd2:    weight = 10;
                            default: weight = 1;
                        endcase
                        ln_year = 14'(int'(ln_year) + int'(d8) * weight);
                    end
                end else begin
                    // Third and later digits are flagged but still folded in.
                    if (ln_digits > 3'd1) mark_error(ln_field);
                    ln_tm[ln_field] = (ln_digits == 3'd0) ? d8
                                    : 8'(ln_tm[ln_field] * 8'd10 + d8);
                end
            end else if (ln_field == trp_pkg::POS_TEMP) begin
                if (c == trp_pkg::CHAR_MINUS) begin
                    ln_neg = 1'b1;
                end else begin
                    term    = ln_neg ? 16'd0 - d16 : d16;
                    ln_temp = (ln_digits == 3'd0) ? term : ln_temp * 16'd10 + term;
                end
            end
            if (ln_digits != trp_pkg::CNT_MAX) ln_digits = ln_digits + 3'd1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers. A line is built in line_bytes and then moved to the
    // send queue with its newline.
    // ------------------------------------------------------------------------
    task automatic push_decimal(input int unsigned val, input int unsigned width);
        logic [7:0] digs[$];
        do begin
            digs.push_front(trp_pkg::CHAR_ZERO + 8'(val % 10));
            val = val / 10;
        end while (val != 0);
        while (digs.size() < width) digs.push_front(trp_pkg::CHAR_ZERO);
        foreach (digs[k]) line_bytes.push_back(digs[k]);
    endtask

    task automatic send_line(input bit hold);
        line_bytes.push_back(trp_pkg::CHAR_NL);
        foreach (line_bytes[k]) chars_to_send.push_back('{line_bytes[k], hold && k == 0});
        chars_queued += line_bytes.size();
        line_bytes.delete();
    endtask

    task automatic send_text(input string s, input bit hold);
        for (int k = 0; k < s.len() - 1; k++) line_bytes.push_back(s[k]);
        send_line(hold);
    endtask

    // Appends the text of one field. Values cluster at the current limits so
    // that both sides of every check are hit, with leading zeros now and then
    // to push the digit counters up to saturation.
    task automatic add_field(input int f);
        int unsigned lim;
        int unsigned val;
        int unsigned width;
        int unsigned roll;
        roll  = $urandom_range(0, 99);
        width = ($urandom_range(0, 99) < 85) ? 1 : $urandom_range(2, 9);
        if (roll < 4) return;   // empty field
        if (f == trp_pkg::POS_YEAR) begin
            roll = $urandom_range(0, 99);
            if (roll < 70)      push_decimal($urandom_range(0, 9999), 4);
            else if (roll < 85) push_decimal($urandom_range(0, 999), 1);
            else                push_decimal($urandom_range(0, 99999), $urandom_range(5, 9));
        end else if (f < trp_pkg::POS_TEMP) begin
            case (f)
                trp_pkg::POS_MONTH: lim = trp_pkg::MONTH_MAX;
                trp_pkg::POS_DAY:   lim = lim_day;
                trp_pkg::POS_HOUR:  lim = lim_hour;
                default:            lim = lim_minute;
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                case ($urandom_range(0, 4))
                    0:       val = 0;
                    1:       val = 1;
                    2:       val = (lim == 0) ? 0 : lim - 1;
                    3:       val = lim;
                    default: val = lim + 1;
                endcase
            end else if (roll < 80) begin
                val = $urandom_range(0, 99);
            end else begin
                val = $urandom_range(0, 999);
            end
            push_decimal(val, width);
        end else if (f == trp_pkg::POS_TEMP) begin
            lim = lim_temp;
            if ($urandom_range(0, 1)) line_bytes.push_back(trp_pkg::CHAR_MINUS);
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                case ($urandom_range(0, 3))
                    0:       val = 0;
                    1:       val = (lim == 0) ? 0 : lim - 1;
                    2:       val = lim;
                    default: val = lim + 1;
                endcase
            end else if (roll < 80) begin
                val = $urandom_range(0, 999);
            end else begin
                val = $urandom_range(0, 99999);
            end
            push_decimal(val, width);
        end else begin
            push_decimal($urandom_range(0, 999), 1);
        end
    endtask

    // Most lines are well formed with random content; the rest carry a stray
    // byte, too many or too few fields, or are plain noise.
    task automatic queue_line();
        int unsigned kind;
        int unsigned nfields;
        logic [7:0]  junk;
        kind = $urandom_range(0, 99);
        if (kind >= 94) begin
            repeat ($urandom_range(0, 20)) begin
                junk = 8'($urandom_range(0, 255));
                if (junk == trp_pkg::CHAR_NL) junk = trp_pkg::CHAR_MINUS;
                line_bytes.push_back(junk);
            end
        end else begin
            nfields = 6;
            if (kind >= 76 && kind < 86) nfields = $urandom_range(7, 10);
            else if (kind >= 86)         nfields = $urandom_range(1, 5);
            for (int f = 0; f < nfields; f++) begin
                if (f != 0) line_bytes.push_back(trp_pkg::CHAR_SEMI);
                add_field(f);
            end
            if (kind >= 60 && kind < 76) begin
                junk = 8'($urandom_range(0, 255));
                if (junk == trp_pkg::CHAR_NL) junk = trp_pkg::CHAR_SEMI;
                line_bytes.insert($urandom_range(0, line_bytes.size()), junk);
            end
        end
        send_line($urandom_range(0, 99) < 3);
    endtask

    // Writes all four limit registers back to back. The spare high bits of
    // the data bus carry noise for the 8-bit registers.
    task automatic write_limits(input logic [7:0] day, input logic [7:0] hour,
                                input logic [7:0] minute, input logic [14:0] temp);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= trp_pkg::REG_MAX_DAY;
        i_cfg_data  <= {7'($urandom), day};
        @(posedge i_clk);
        i_cfg_index <= trp_pkg::REG_MAX_HOUR;
        i_cfg_data  <= {7'($urandom), hour};
        @(posedge i_clk);
        i_cfg_index <= trp_pkg::REG_MAX_MINUTE;
        i_cfg_data  <= {7'($urandom), minute};
        @(posedge i_clk);
        i_cfg_index <= trp_pkg::REG_TEMP_LIMIT;
        i_cfg_data  <= temp;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        lim_day    = day;
        lim_hour   = hour;
        lim_minute = minute;
        lim_temp   = temp;
    endtask

    // Returns once every byte is in and every record is out, then lets the
    // pipeline settle before the limits may change.
    task automatic wait_drained();
        @(negedge i_clk);
        while (chars_to_send.size() != 0 || i_valid || records_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what);
        failures++;
        if (failures <= 10) $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v, input logic [31:0] line);
        if (got_v !== want_v)
            report_mismatch($sformatf("line %0d %s expected %0h got %0h",
                                      line, name, want_v, got_v));
    endtask

    // ------------------------------------------------------------------------
    // Source side. A byte stays on the bus until it is taken; afterwards the
    // source may sit out a random gap. A byte marked hold is not presented
    // while any record is still outstanding.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : byte_driver
        logic busy;
        busy = i_valid;
        if (i_rst_n && i_valid && !o_stall) begin
            parse_char(i_char_byte);
            busy     = 1'b0;
            gap_left = src_idle ? pick_gap(30) : 0;
        end
        if (i_rst_n && !busy) begin
            if (gap_left != 0) begin
                gap_left--;
            end else if (chars_to_send.size() != 0 &&
                         !(chars_to_send[0].hold && records_due.size() != 0)) begin
                i_char_byte <= chars_to_send[0].ch;
                busy = 1'b1;
                void'(chars_to_send.pop_front());
            end
        end
        i_valid <= busy;
    end

    // ------------------------------------------------------------------------
    // Sink side. Every record beat is checked against the oldest prediction.
    // Stalls come in random runs, and i_stall always drops again between two runs.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : record_monitor
        t_record want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (records_due.size() == 0) begin
                report_mismatch($sformatf("record for line %0d with no line pending",
                                          o_line_index));
            end else begin
                want = records_due.pop_front();
                check_field("year",     32'(want.year),   32'(o_year_value),     want.line);
                check_field("month",    32'(want.month),  32'(o_month_value),    want.line);
                check_field("day",      32'(want.day),    32'(o_day_value),      want.line);
                check_field("hour",     32'(want.hour),   32'(o_hour_value),     want.line);
                check_field("minute",   32'(want.minute), 32'(o_minute_value),   want.line);
                check_field("temp",     {16'h0, want.temp}, {16'h0, o_temperature}, want.line);
                check_field("line",     want.line,        o_line_index,          want.line);
                check_field("err_flag", 32'(want.err),    32'(o_error_flag),     want.line);
                check_field("err_pos",  32'(want.pos),    32'(o_error_position), want.line);
            end
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (i_stall) begin
            i_stall <= 1'b0;
        end else begin
            stall_left = snk_idle ? pick_gap(40) : 0;
            if (stall_left != 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end
        end
    end

    // Watchdog: any beat on either channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d records outstanding",
                     quiet_cycles, records_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [14:0] temp;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed lines under the reset limits: a record sitting exactly on
        // every limit, then a line with a five-digit year and extra fields.
        // The second one is held back until the first record is out.
        send_text("9999;12;31;24;60;-99\n", 1'b0);
        send_text("12345;;;;;;\n", 1'b1);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    day = 8'd255; hour = 8'd255; minute = 8'd255; temp = 15'h7FFF;
                end
                1: begin
                    day = 8'd1; hour = 8'd0; minute = 8'd0; temp = 15'd0;
                end
                default: begin
                    if ($urandom_range(0, 1)) begin
                        day    = 8'($urandom_range(28, 31));
                        hour   = 8'($urandom_range(23, 24));
                        minute = 8'($urandom_range(59, 60));
                        temp   = 15'($urandom_range(40, 150));
                    end else begin
                        day    = 8'($urandom_range(1, 255));
                        hour   = 8'($urandom_range(0, 255));
                        minute = 8'($urandom_range(0, 255));
                        temp   = 15'($urandom_range(0, 32767));
                    end
                end
            endcase
            write_limits(day, hour, minute, temp);
            @(negedge i_clk);
            // Rotate through both sides idling, neither, and each alone.
            src_idle = (p % 4 == 0) || (p % 4 == 2);
            snk_idle = (p % 4 == 0) || (p % 4 == 3);
            chars_queued = 0;
            while (chars_queued < PHASE_BYTES) queue_line();
            wait_drained();
        end

        // Leave room for any stray record beat to show up.
        repeat (8) @(posedge i_clk);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
